// File: rtl/poc_pkg.sv
package poc_pkg;

	// Coordinate width and the widths of the offset datapath that follow from it.
	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int HW_BITS    = 31;
	localparam int NORM_BITS  = 31;
	localparam int PROD_BITS  = 2 * NORM_BITS;
	localparam int NUM_BITS   = PROD_BITS + 1;
	localparam int ROOT_BITS  = NORM_BITS + 1;
	localparam int OFS_BITS   = HW_BITS + 1;
	localparam int SUM_BITS   = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 1;

	localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(65536);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         last_point;
	} point_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] right_x;
		logic signed [COORD_BITS-1:0] right_y;
		logic signed [COORD_BITS-1:0] left_x;
		logic signed [COORD_BITS-1:0] left_y;
		logic                         line_end;
		logic                         degenerate;
	} corner_t;

	// Offset vector produced by the offset unit for one tangent.
	typedef struct packed {
		logic signed [OFS_BITS-1:0] ox;
		logic signed [OFS_BITS-1:0] oy;
		logic                       degenerate;
	} ofs_t;

endpackage

// File: rtl/poc_mul.sv
module poc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [poc_pkg::NORM_BITS-1:0] a,
	input  logic [poc_pkg::NORM_BITS-1:0] b,
	output logic [poc_pkg::PROD_BITS-1:0] p,
	output logic                          done
);
	import poc_pkg::*;

	localparam int CNT_BITS = $clog2(NORM_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [NORM_BITS-1:0] a_q;
	logic [NORM_BITS-1:0] b_q;
	logic [PROD_BITS-1:0] acc_q;

	// Shift-and-add, multiplier scanned from its top bit, one bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NORM_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1) + (b_q[NORM_BITS-1] ? PROD_BITS'(a_q) : '0);
			b_q   <= b_q << 1;
		end
	end

	assign p    = acc_q;
	assign done = done_q;

endmodule

// File: rtl/poc_sqrt.sv
module poc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [poc_pkg::NUM_BITS-1:0]  n,
	output logic [poc_pkg::ROOT_BITS-1:0] root,
	output logic                          done
);
	import poc_pkg::*;

	localparam int RAD_BITS = 2 * ROOT_BITS;
	localparam int REM_BITS = ROOT_BITS + 3;
	localparam int CNT_BITS = $clog2(ROOT_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [REM_BITS-1:0]  r4;
	logic [REM_BITS-1:0]  trial;
	logic                 ge;

	// Digit-by-digit square root: two radicand bits in, one root bit out per cycle.
	assign r4    = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial = REM_BITS'({root_q, 2'b01});
	assign ge    = (r4 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_BITS'(n);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (r4 - trial) : r4;
			root_q <= {root_q[ROOT_BITS-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// File: rtl/poc_div.sv
module poc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [poc_pkg::NUM_BITS-1:0]  num,
	input  logic [poc_pkg::ROOT_BITS-1:0] den,
	output logic [poc_pkg::HW_BITS-1:0]   quo,
	output logic                          done
);
	import poc_pkg::*;

	localparam int CNT_BITS = $clog2(HW_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [ROOT_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] den_q;
	logic [HW_BITS-1:0]   low_q;
	logic [HW_BITS-1:0]   quo_q;
	logic [ROOT_BITS:0]   r2;
	logic [ROOT_BITS:0]   diff;
	logic                 ge;

	// Restoring division. The quotient is known to fit HW_BITS, so the upper part
	// of the numerator is already below the divisor and serves as the first remainder.
	assign r2   = {rem_q, low_q[HW_BITS-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(HW_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_BITS-1:HW_BITS];
			low_q <= num[HW_BITS-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ROOT_BITS-1:0] : r2[ROOT_BITS-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[HW_BITS-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// File: rtl/poc_offset.sv
module poc_offset (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [poc_pkg::DIFF_BITS-1:0] dx,
	input  logic signed [poc_pkg::DIFF_BITS-1:0] dy,
	input  logic [poc_pkg::HW_BITS-1:0]          ofs_width,
	output poc_pkg::ofs_t                        res,
	output logic                                 done
);
	import poc_pkg::*;

	typedef enum logic [4:0] {
		OS_IDLE = 5'b00001,
		OS_NORM = 5'b00010,
		OS_MUL  = 5'b00100,
		OS_ROOT = 5'b01000,
		OS_DIV  = 5'b10000
	} ofs_state_t;

	ofs_state_t            st_q;
	logic                  sx_q;
	logic                  sy_q;
	logic [COORD_BITS-1:0] ax_q;
	logic [COORD_BITS-1:0] ay_q;
	ofs_t                  res_q;
	logic                  done_q;

	logic [DIFF_BITS-1:0]  mag_x;
	logic [DIFF_BITS-1:0]  mag_y;
	logic                  zero_diff;
	logic                  need_shift;
	logic                  mul_start;
	logic                  sqrt_start;
	logic                  div_start;
	logic [PROD_BITS-1:0]  sqx_p;
	logic [PROD_BITS-1:0]  sqy_p;
	logic [PROD_BITS-1:0]  prx_p;
	logic [PROD_BITS-1:0]  pry_p;
	logic [3:0]            mul_done;
	logic [NUM_BITS-1:0]   rad;
	logic [ROOT_BITS-1:0]  len;
	logic                  sqrt_done;
	logic [NUM_BITS-1:0]   num_x;
	logic [NUM_BITS-1:0]   num_y;
	logic [HW_BITS-1:0]    qx;
	logic [HW_BITS-1:0]    qy;
	logic [1:0]            div_done;

	assign mag_x     = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
	assign mag_y     = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
	assign zero_diff = (dx == '0) && (dy == '0);

	// Magnitudes are scaled down one bit a cycle until both fit NORM_BITS.
	assign need_shift = ((ax_q | ay_q) >> NORM_BITS) != '0;
	assign mul_start  = (st_q == OS_NORM) && !need_shift;
	assign sqrt_start = (st_q == OS_MUL) && (&mul_done);
	assign div_start  = (st_q == OS_ROOT) && sqrt_done;

	assign rad   = {1'b0, sqx_p} + {1'b0, sqy_p};
	assign num_x = {1'b0, prx_p} + NUM_BITS'(len >> 1);
	assign num_y = {1'b0, pry_p} + NUM_BITS'(len >> 1);

	poc_mul u_sqx (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(ax_q[NORM_BITS-1:0]), .b(ax_q[NORM_BITS-1:0]), .p(sqx_p), .done(mul_done[0])
	);

	poc_mul u_sqy (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(ay_q[NORM_BITS-1:0]), .b(ay_q[NORM_BITS-1:0]), .p(sqy_p), .done(mul_done[1])
	);

	poc_mul u_prx (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(ofs_width), .b(ax_q[NORM_BITS-1:0]), .p(prx_p), .done(mul_done[2])
	);

	poc_mul u_pry (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(ofs_width), .b(ay_q[NORM_BITS-1:0]), .p(pry_p), .done(mul_done[3])
	);

	poc_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.n(rad), .root(len), .done(sqrt_done)
	);

	poc_div u_divx (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_x), .den(len), .quo(qx), .done(div_done[0])
	);

	poc_div u_divy (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_y), .den(len), .quo(qy), .done(div_done[1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= OS_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				OS_IDLE: begin
					if (start) begin
						if (zero_diff) begin
							done_q <= 1'b1;
						end else begin
							st_q <= OS_NORM;
						end
					end
				end
				OS_NORM: begin
					if (!need_shift) begin
						st_q <= OS_MUL;
					end
				end
				OS_MUL: begin
					if (&mul_done) begin
						st_q <= OS_ROOT;
					end
				end
				OS_ROOT: begin
					if (sqrt_done) begin
						st_q <= OS_DIV;
					end
				end
				OS_DIV: begin
					if (&div_done) begin
						st_q   <= OS_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= OS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == OS_IDLE && start) begin
			sx_q <= dx[DIFF_BITS-1];
			sy_q <= dy[DIFF_BITS-1];
			ax_q <= mag_x[COORD_BITS-1:0];
			ay_q <= mag_y[COORD_BITS-1:0];
			if (zero_diff) begin
				res_q.ox         <= '0;
				res_q.oy         <= '0;
				res_q.degenerate <= 1'b1;
			end
		end else if (st_q == OS_NORM && need_shift) begin
			ax_q <= ax_q >> 1;
			ay_q <= ay_q >> 1;
		end else if (st_q == OS_DIV && (&div_done)) begin
			res_q.ox         <= sx_q ? -{1'b0, qx} : {1'b0, qx};
			res_q.oy         <= sy_q ? -{1'b0, qy} : {1'b0, qy};
			res_q.degenerate <= 1'b0;
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

// File: rtl/polyline_offset_corners.sv
// Polyline corner generator.
// Points of a polyline enter on the point channel (point_valid / point_ready),
// one item each, with last_point set on the final point of a line. Corner
// pairs leave on the corner channel (corner_valid / corner_ready). The results
// lag one point: the first point of a line gives nothing, every later point
// gives the result of the point before it, and the last point also gives its
// own, so it produces two items. A line of one point gives one degenerate item.
// The cfg channel writes the offset width (half the road width); it is always
// ready and is meant to be written while the block is idle.
// Each result with a non-zero tangent passes from acceptance to the output
// register through range scaling when a difference needs the full 32 bits,
// then the bit-serial multipliers, the square root and the dividers, one bit
// per cycle each. Points are taken only while no result is in work, so a
// closing point occupies the block until both of its results are done.
// A finished item sits in the output register; the next point is accepted
// while it waits, and the following result stays parked until the receiver
// takes the register. Reset empties both channels, forgets any partial line
// and sets the offset width to 1.0.
module polyline_offset_corners (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [poc_pkg::HW_BITS-1:0] cfg_data,
	input  logic                        point_valid,
	output logic                        point_ready,
	input  poc_pkg::point_t             point_data,
	output logic                        corner_valid,
	input  logic                        corner_ready,
	output poc_pkg::corner_t            corner_data
);
	import poc_pkg::*;

	// Top-level sequencing: wait for a point, run the offset unit, park a result.
	typedef enum logic [2:0] {
		TS_IDLE = 3'b001,
		TS_RUN  = 3'b010,
		TS_HOLD = 3'b100
	} top_state_t;

	// One pending result: the point to offset, its tangent and the end flag.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [DIFF_BITS-1:0]  dx;
		logic signed [DIFF_BITS-1:0]  dy;
		logic                         line_end;
	} job_t;

	// Number of points seen on the current line, saturating at two.
	localparam logic [1:0] PS_NONE = 2'd0;
	localparam logic [1:0] PS_ONE  = 2'd1;
	localparam logic [1:0] PS_MANY = 2'd2;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	top_state_t                   st_q;
	logic [1:0]                   ps_q;
	logic                         has_next_q;
	logic                         off_start_q;
	logic                         corner_valid_q;
	logic [HW_BITS-1:0]           ofs_width_q;
	logic signed [COORD_BITS-1:0] pending_x_q;
	logic signed [COORD_BITS-1:0] pending_y_q;
	logic signed [COORD_BITS-1:0] before_x_q;
	logic signed [COORD_BITS-1:0] before_y_q;
	job_t                         cur_q;
	job_t                         nxt_q;
	corner_t                      corner_q;

	logic                         accept;
	logic signed [DIFF_BITS-1:0]  d_back_x;
	logic signed [DIFF_BITS-1:0]  d_back_y;
	logic signed [DIFF_BITS-1:0]  d_cent_x;
	logic signed [DIFF_BITS-1:0]  d_cent_y;
	job_t                         job_prev;
	job_t                         job_last;
	job_t                         job_single;
	ofs_t                         off_res;
	logic                         off_done;
	logic                         out_free;
	logic                         load;
	corner_t                      corner_next;

	// Point plus or minus an offset, clamped to the coordinate range.
	function automatic logic [COORD_BITS-1:0] sat_sum(
		input logic signed [COORD_BITS-1:0] base,
		input logic signed [OFS_BITS-1:0]   ofs,
		input logic                         neg
	);
		logic signed [SUM_BITS-1:0]       s;
		logic [SUM_BITS-COORD_BITS:0]     top;
		logic [COORD_BITS-1:0]            r;
		s   = neg ? (SUM_BITS'(base) - SUM_BITS'(ofs)) : (SUM_BITS'(base) + SUM_BITS'(ofs));
		top = s[SUM_BITS-1:COORD_BITS-1];
		if ((&top) || !(|top)) begin
			r = s[COORD_BITS-1:0];
		end else if (s[SUM_BITS-1]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
		return r;
	endfunction

	assign cfg_ready   = 1'b1;
	assign point_ready = (st_q == TS_IDLE);
	assign accept      = point_valid && point_ready;

	// Backward difference from the pending point, central from the one before it.
	assign d_back_x = DIFF_BITS'(point_data.point_x) - DIFF_BITS'(pending_x_q);
	assign d_back_y = DIFF_BITS'(point_data.point_y) - DIFF_BITS'(pending_y_q);
	assign d_cent_x = DIFF_BITS'(point_data.point_x) - DIFF_BITS'(before_x_q);
	assign d_cent_y = DIFF_BITS'(point_data.point_y) - DIFF_BITS'(before_y_q);

	always_comb begin
		job_prev.px       = pending_x_q;
		job_prev.py       = pending_y_q;
		job_prev.dx       = (ps_q == PS_ONE) ? d_back_x : d_cent_x;
		job_prev.dy       = (ps_q == PS_ONE) ? d_back_y : d_cent_y;
		job_prev.line_end = 1'b0;

		job_last.px       = point_data.point_x;
		job_last.py       = point_data.point_y;
		job_last.dx       = d_back_x;
		job_last.dy       = d_back_y;
		job_last.line_end = 1'b1;

		job_single.px       = point_data.point_x;
		job_single.py       = point_data.point_y;
		job_single.dx       = '0;
		job_single.dy       = '0;
		job_single.line_end = 1'b1;
	end

	poc_offset u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (off_start_q),
		.dx        (cur_q.dx),
		.dy        (cur_q.dy),
		.ofs_width (ofs_width_q),
		.res       (off_res),
		.done      (off_done)
	);

	// Right normal is (ty, -tx), left normal is (-ty, tx).
	always_comb begin
		corner_next.right_x    = sat_sum(cur_q.px, off_res.oy, 1'b0);
		corner_next.right_y    = sat_sum(cur_q.py, off_res.ox, 1'b1);
		corner_next.left_x     = sat_sum(cur_q.px, off_res.oy, 1'b1);
		corner_next.left_y     = sat_sum(cur_q.py, off_res.ox, 1'b0);
		corner_next.line_end   = cur_q.line_end;
		corner_next.degenerate = off_res.degenerate;
	end

	assign out_free = !corner_valid_q || corner_ready;
	assign load     = out_free && (((st_q == TS_RUN) && off_done) || (st_q == TS_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= TS_IDLE;
			ps_q           <= PS_NONE;
			has_next_q     <= 1'b0;
			off_start_q    <= 1'b0;
			corner_valid_q <= 1'b0;
			ofs_width_q    <= HW_RESET;
		end else begin
			off_start_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				ofs_width_q <= cfg_data;
			end
			if (corner_valid_q && corner_ready) begin
				corner_valid_q <= 1'b0;
			end
			if (load) begin
				corner_valid_q <= 1'b1;
			end
			unique case (st_q)
				TS_IDLE: begin
					if (accept) begin
						if (ps_q == PS_NONE) begin
							if (point_data.last_point) begin
								off_start_q <= 1'b1;
								st_q        <= TS_RUN;
							end else begin
								ps_q <= PS_ONE;
							end
						end else begin
							off_start_q <= 1'b1;
							st_q        <= TS_RUN;
							if (point_data.last_point) begin
								has_next_q <= 1'b1;
								ps_q       <= PS_NONE;
							end else begin
								ps_q <= PS_MANY;
							end
						end
					end
				end
				TS_RUN, TS_HOLD: begin
					if (load) begin
						if (has_next_q) begin
							has_next_q  <= 1'b0;
							off_start_q <= 1'b1;
							st_q        <= TS_RUN;
						end else begin
							st_q <= TS_IDLE;
						end
					end else if (off_done) begin
						st_q <= TS_HOLD;
					end
				end
				default: begin
					st_q <= TS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (ps_q == PS_NONE) begin
				if (point_data.last_point) begin
					cur_q <= job_single;
				end else begin
					pending_x_q <= point_data.point_x;
					pending_y_q <= point_data.point_y;
				end
			end else begin
				cur_q <= job_prev;
				if (point_data.last_point) begin
					nxt_q <= job_last;
				end else begin
					before_x_q  <= pending_x_q;
					before_y_q  <= pending_y_q;
					pending_x_q <= point_data.point_x;
					pending_y_q <= point_data.point_y;
				end
			end
		end
		if (load) begin
			corner_q <= corner_next;
			if (has_next_q) begin
				cur_q <= nxt_q;
			end
		end
	end

	assign corner_valid = corner_valid_q;
	assign corner_data  = corner_q;

	// New points are taken only once the closing point's second result has started.
	a_ready_no_queue: assert property (@(posedge clk) disable iff (!arst_n)
		point_ready |-> !has_next_q)
		else $error("point accepted while a second result is still queued");

	// A parked result exists only while the output register is occupied.
	a_hold_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == TS_HOLD) |-> corner_valid_q)
		else $error("result parked although the output register is free");

	// The offset unit finishes only while a result is being worked on.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		off_done |-> (st_q == TS_RUN))
		else $error("offset unit finished outside of a run");

	// While two results are queued, the current one is interior and the next closes the line.
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		has_next_q |-> (!cur_q.line_end && nxt_q.line_end))
		else $error("queued results out of order");

endmodule
